>>> rtl/core/dlbb_pkg.sv
// dlbb_pkg: shared types and codes of the dual led blink and breathe controller
// no dependencies; used by dlbb_core and dual_led_blink_breathe_controller
package dlbb_pkg;

    // led modes, same encoding on the input item and the result item
    localparam logic [2:0] MODE_TEMP    = 3'd0;
    localparam logic [2:0] MODE_BLINK   = 3'd1;
    localparam logic [2:0] MODE_ON      = 3'd2;
    localparam logic [2:0] MODE_OFF     = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;

    // item opcodes
    localparam logic [1:0] OP_SET_MODE  = 2'd0;
    localparam logic [1:0] OP_SLOW_TICK = 2'd1;
    localparam logic [1:0] OP_FAST_TICK = 2'd2;

    // register indexes on the apb port
    localparam logic [1:0] REG_BLINK_DIVIDE     = 2'd0;
    localparam logic [1:0] REG_TEMP_BLINK_LIMIT = 2'd1;
    localparam logic [1:0] REG_PWM_TOP          = 2'd2;
    localparam logic [1:0] REG_RAMP_HOLD        = 2'd3;

    // register reset values
    localparam logic [7:0] RST_BLINK_DIVIDE     = 8'd2;
    localparam logic [7:0] RST_TEMP_BLINK_LIMIT = 8'd6;
    localparam logic [7:0] RST_PWM_TOP          = 8'd100;
    localparam logic [7:0] RST_RAMP_HOLD        = 8'd50;

    typedef struct packed {
        logic [7:0] blink_divide;
        logic [7:0] temp_blink_limit;
        logic [7:0] pwm_top;
        logic [7:0] ramp_hold;
    } t_cfg;

    // one decoded input item
    typedef struct packed {
        logic [1:0] opcode;
        logic       led_select;
        logic [2:0] new_mode;
    } t_item;

    // controller state; pins bit 0 green, bit 1 red
    typedef struct packed {
        logic [2:0] green_mode;
        logic [2:0] red_mode;
        logic [2:0] saved_mode;
        logic [1:0] pins;
        logic [7:0] blink_count;
        logic [7:0] toggle_count;
        logic       pwm_en;
        logic [7:0] pwm_phase;
        logic [7:0] hold_count;
        logic [7:0] duty_width;
        logic       ramp_up;
    } t_state;

endpackage

>>> rtl/core/dlbb_core.sv
// dlbb_core: led mode and pwm state register with its single-pass update
// depends on dlbb_pkg
module dlbb_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  dlbb_pkg::t_item i_item,
    input  dlbb_pkg::t_cfg  i_cfg,
    output dlbb_pkg::t_state o_state,
    output dlbb_pkg::t_state o_next
);

    dlbb_pkg::t_state r_state;
    dlbb_pkg::t_state n_state;

    // set one led's mode, shared by set-mode items and temp blink restore
    function automatic dlbb_pkg::t_state apply_mode(dlbb_pkg::t_state s,
                                                    logic led,
                                                    logic [2:0] mode,
                                                    dlbb_pkg::t_cfg cfg);
        dlbb_pkg::t_state r;
        logic [2:0] self_m;
        logic [2:0] other_m;
        logic [1:0] bitm;
        r       = s;
        self_m  = led ? s.red_mode : s.green_mode;
        other_m = led ? s.green_mode : s.red_mode;
        bitm    = led ? 2'b10 : 2'b01;
        if (mode <= dlbb_pkg::MODE_BREATHE) begin
            if (other_m != dlbb_pkg::MODE_BREATHE) r.pwm_en = 1'b0;
            case (mode)
                dlbb_pkg::MODE_TEMP: begin
                    if (self_m != dlbb_pkg::MODE_TEMP) begin
                        r.saved_mode = self_m;
                        self_m       = dlbb_pkg::MODE_TEMP;
                    end
                end
                dlbb_pkg::MODE_BLINK: begin
                    self_m = dlbb_pkg::MODE_BLINK;
                end
                dlbb_pkg::MODE_ON: begin
                    self_m = dlbb_pkg::MODE_ON;
                    r.pins = r.pins | bitm;
                end
                dlbb_pkg::MODE_OFF: begin
                    self_m = dlbb_pkg::MODE_OFF;
                    r.pins = r.pins & ~bitm;
                end
                dlbb_pkg::MODE_BREATHE: begin
                    self_m = dlbb_pkg::MODE_BREATHE;
                    if (other_m != dlbb_pkg::MODE_BREATHE) begin
                        r.pwm_phase  = cfg.pwm_top - 8'd1;
                        r.hold_count = 8'd0;
                        r.duty_width = cfg.pwm_top;
                        r.ramp_up    = 1'b0;
                        r.pwm_en     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (led) r.red_mode = self_m;
            else     r.green_mode = self_m;
        end
        return r;
    endfunction

    // slow tick: toggle the first blinking led, restore after a temp blink
    function automatic dlbb_pkg::t_state slow_tick(dlbb_pkg::t_state s,
                                                   dlbb_pkg::t_cfg cfg);
        dlbb_pkg::t_state r;
        logic led;
        logic found;
        logic [2:0] mode;
        r     = s;
        led   = 1'b0;
        found = 1'b1;
        if (s.green_mode < dlbb_pkg::MODE_ON)    led = 1'b0;
        else if (s.red_mode < dlbb_pkg::MODE_ON) led = 1'b1;
        else                                     found = 1'b0;
        mode = led ? s.red_mode : s.green_mode;
        if (found) begin
            r.blink_count = s.blink_count + 8'd1;
            if (r.blink_count > cfg.blink_divide) begin
                r.pins        = r.pins ^ (led ? 2'b10 : 2'b01);
                r.blink_count = 8'd0;
                if (mode == dlbb_pkg::MODE_TEMP) begin
                    r.toggle_count = s.toggle_count + 8'd1;
                    if (r.toggle_count > cfg.temp_blink_limit) begin
                        r = apply_mode(r, led, r.saved_mode, cfg);
                        r.toggle_count = 8'd0;
                    end
                end
            end
        end
        return r;
    endfunction

    // fast tick: pwm phase, width ramp and breathing pins
    function automatic dlbb_pkg::t_state fast_tick(dlbb_pkg::t_state s,
                                                   dlbb_pkg::t_cfg cfg);
        dlbb_pkg::t_state r;
        logic drive;
        logic hit;
        r     = s;
        drive = 1'b0;
        hit   = 1'b0;
        if (s.pwm_en) begin
            r.pwm_phase = s.pwm_phase + 8'd1;
            if (r.pwm_phase > cfg.pwm_top) begin
                r.pwm_phase  = 8'd0;
                r.hold_count = s.hold_count + 8'd1;
                if (r.hold_count > cfg.ramp_hold) begin
                    r.hold_count = 8'd0;
                    if (s.ramp_up) begin
                        r.duty_width = s.duty_width + 8'd1;
                        if (r.duty_width > cfg.pwm_top) r.ramp_up = 1'b0;
                    end else begin
                        r.duty_width = s.duty_width - 8'd1;
                        if (r.duty_width < 8'd2) r.ramp_up = 1'b1;
                    end
                end
            end
            if (r.pwm_phase == 8'd0) begin
                hit   = 1'b1;
                drive = 1'b0;
            end else if (r.pwm_phase == r.duty_width) begin
                hit   = 1'b1;
                drive = 1'b1;
            end
            if (hit && r.red_mode == dlbb_pkg::MODE_BREATHE)   r.pins[1] = drive;
            if (hit && r.green_mode == dlbb_pkg::MODE_BREATHE) r.pins[0] = drive;
        end
        return r;
    endfunction

    // next state for the item in the input register
    always_comb begin
        n_state = r_state;
        if (i_en) begin
            case (i_item.opcode)
                dlbb_pkg::OP_SET_MODE:
                    n_state = apply_mode(r_state, i_item.led_select, i_item.new_mode, i_cfg);
                dlbb_pkg::OP_SLOW_TICK: n_state = slow_tick(r_state, i_cfg);
                dlbb_pkg::OP_FAST_TICK: n_state = fast_tick(r_state, i_cfg);
                default: begin
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{green_mode: dlbb_pkg::MODE_OFF, red_mode: dlbb_pkg::MODE_OFF,
                         saved_mode: dlbb_pkg::MODE_OFF, default: '0};
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

endmodule

>>> rtl/core/dual_led_blink_breathe_controller.sv
// dual_led_blink_breathe_controller: top level with stream ports and apb registers
// depends on dlbb_pkg and dlbb_core
//
// Drives a green and a red led from a stream of items: set-mode commands, slow
// blink ticks and fast pwm ticks. Each item passes an input register, is applied
// to the led state and yields one result item (pins and modes after the item) in
// an output register. One item is taken every clock while the result side does not
// stall; a stalled result register holds the next item in the input register. The state
// update is a single pass of compares and 8-bit increments and decrements. Registers
// (byte addresses 0, 4, 8, 12): blink_divide, temp_blink_limit, pwm_top, ramp_hold;
// write them only while no item is in flight.
module dual_led_blink_breathe_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] new_mode, [7:3] zero
    input  logic [2:0]  s_axis_tuser,   // [1:0] opcode, [2] led_select
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] green_pin, [1] red_pin,
                                        // [4:2] green_state, [7:5] red_state
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dlbb_pkg::t_cfg   r_cfg;
    dlbb_pkg::t_item  r_item;
    logic             r_in_valid;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    dlbb_pkg::t_state w_state;
    dlbb_pkg::t_state w_next;
    logic             w_out_load;
    logic             w_adv;
    logic             w_cfg_wr;
    logic [1:0]       w_reg_idx;

    // register port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_divide     <= dlbb_pkg::RST_BLINK_DIVIDE;
            r_cfg.temp_blink_limit <= dlbb_pkg::RST_TEMP_BLINK_LIMIT;
            r_cfg.pwm_top          <= dlbb_pkg::RST_PWM_TOP;
            r_cfg.ramp_hold        <= dlbb_pkg::RST_RAMP_HOLD;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                dlbb_pkg::REG_BLINK_DIVIDE:     r_cfg.blink_divide     <= pwdata[7:0];
                dlbb_pkg::REG_TEMP_BLINK_LIMIT: r_cfg.temp_blink_limit <= pwdata[7:0];
                dlbb_pkg::REG_PWM_TOP:          r_cfg.pwm_top          <= pwdata[7:0];
                dlbb_pkg::REG_RAMP_HOLD:        r_cfg.ramp_hold        <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            dlbb_pkg::REG_BLINK_DIVIDE:     prdata = {24'd0, r_cfg.blink_divide};
            dlbb_pkg::REG_TEMP_BLINK_LIMIT: prdata = {24'd0, r_cfg.temp_blink_limit};
            dlbb_pkg::REG_PWM_TOP:          prdata = {24'd0, r_cfg.pwm_top};
            dlbb_pkg::REG_RAMP_HOLD:        prdata = {24'd0, r_cfg.ramp_hold};
            default:                        prdata = 32'd0;
        endcase
    end

    // flow control: the item in the input register moves on when the
    // output register is free or being emptied
    assign w_out_load    = ~r_out_valid | m_axis_tready;
    assign w_adv         = r_in_valid & w_out_load;
    assign s_axis_tready = ~r_in_valid | w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.opcode     <= s_axis_tuser[1:0];
            r_item.led_select <= s_axis_tuser[2];
            r_item.new_mode   <= s_axis_tdata[2:0];
        end
    end

    // state update
    dlbb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_state (w_state),
        .o_next  (w_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {w_next.red_mode, w_next.green_mode, w_next.pins[1], w_next.pins[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // modes stay within the defined codes
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.green_mode <= dlbb_pkg::MODE_BREATHE
        && w_state.red_mode <= dlbb_pkg::MODE_BREATHE)
        else $error("led mode out of range");

    // the pwm only runs while some led is breathing
    a_pwm_needs_breathe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.pwm_en |-> (w_state.green_mode == dlbb_pkg::MODE_BREATHE
                            || w_state.red_mode == dlbb_pkg::MODE_BREATHE))
        else $error("pwm enabled with no breathing led");

    // green on and off modes hold their pin level
    a_green_static_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state.green_mode == dlbb_pkg::MODE_ON && !w_state.pins[0]) == 1'b0
        && (w_state.green_mode == dlbb_pkg::MODE_OFF && w_state.pins[0]) == 1'b0)
        else $error("green pin disagrees with static mode");

    // an item that moves on always lands in the result register
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("item lost between input and result register");

    // a held item stays in the input register
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("stalled item dropped");

endmodule

>>> verif/tb_dual_led_blink_breathe_controller.sv
// testbench for dual_led_blink_breathe_controller: stream items in, led pins and modes out
// holds its own led state predictor in a small scoreboard class; needs dlbb_pkg and the rtl
`timescale 1ns / 100ps

module tb_dual_led_blink_breathe_controller;

    // opcode the block leaves alone
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4;

    // predicts pins and modes of each item and checks them against the results
    class led_scoreboard;
        dlbb_pkg::t_cfg   cfg;
        dlbb_pkg::t_state st;
        logic [7:0]       outcome_q[$];
        int               errors;

        function new();
            errors = 0;
            cfg = '{blink_divide:     dlbb_pkg::RST_BLINK_DIVIDE,
                    temp_blink_limit: dlbb_pkg::RST_TEMP_BLINK_LIMIT,
                    pwm_top:          dlbb_pkg::RST_PWM_TOP,
                    ramp_hold:        dlbb_pkg::RST_RAMP_HOLD};
            st = '0;
            st.green_mode = dlbb_pkg::MODE_OFF;
            st.red_mode   = dlbb_pkg::MODE_OFF;
            st.saved_mode = dlbb_pkg::MODE_OFF;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                dlbb_pkg::REG_BLINK_DIVIDE:     cfg.blink_divide     = val;
                dlbb_pkg::REG_TEMP_BLINK_LIMIT: cfg.temp_blink_limit = val;
                dlbb_pkg::REG_PWM_TOP:          cfg.pwm_top          = val;
                dlbb_pkg::REG_RAMP_HOLD:        cfg.ramp_hold        = val;
                default: ;
            endcase
        endfunction

        // set-mode command for one led
        function void apply_mode(logic led, logic [2:0] mode);
            logic [2:0] own;
            logic [2:0] other;
            logic [1:0] pin_mask;
            own      = led ? st.red_mode : st.green_mode;
            other    = led ? st.green_mode : st.red_mode;
            pin_mask = led ? 2'b10 : 2'b01;
            if (mode > dlbb_pkg::MODE_BREATHE) return;
            if (other != dlbb_pkg::MODE_BREATHE) st.pwm_en = 1'b0;
            case (mode)
                dlbb_pkg::MODE_TEMP: begin
                    if (own != dlbb_pkg::MODE_TEMP) begin
                        st.saved_mode = own;
                        own = dlbb_pkg::MODE_TEMP;
                    end
                end
                dlbb_pkg::MODE_BLINK: own = dlbb_pkg::MODE_BLINK;
                dlbb_pkg::MODE_ON: begin
                    own = dlbb_pkg::MODE_ON;
                    st.pins = st.pins | pin_mask;
                end
                dlbb_pkg::MODE_OFF: begin
                    own = dlbb_pkg::MODE_OFF;
                    st.pins = st.pins & ~pin_mask;
                end
                default: begin
                    own = dlbb_pkg::MODE_BREATHE;
                    // restart the breathing ramp unless the other led already runs it
                    if (other != dlbb_pkg::MODE_BREATHE) begin
                        st.pwm_phase  = cfg.pwm_top - 8'd1;
                        st.hold_count = 8'd0;
                        st.duty_width = cfg.pwm_top;
                        st.ramp_up    = 1'b0;
                        st.pwm_en     = 1'b1;
                    end
                end
            endcase
            if (led) st.red_mode = own;
            else st.green_mode = own;
        endfunction

        // slow tick: toggle the first blinking led, green before red
        function void blink_tick();
            logic       led;
            logic [2:0] mode;
            if (st.green_mode < dlbb_pkg::MODE_ON) led = 1'b0;
            else if (st.red_mode < dlbb_pkg::MODE_ON) led = 1'b1;
            else return;
            mode = led ? st.red_mode : st.green_mode;
            st.blink_count = st.blink_count + 8'd1;
            if (st.blink_count > cfg.blink_divide) begin
                st.pins = st.pins ^ (led ? 2'b10 : 2'b01);
                st.blink_count = 8'd0;
                if (mode == dlbb_pkg::MODE_TEMP) begin
                    st.toggle_count = st.toggle_count + 8'd1;
                    // temporary blink over: fall back to the saved mode
                    if (st.toggle_count > cfg.temp_blink_limit) begin
                        apply_mode(led, st.saved_mode);
                        st.toggle_count = 8'd0;
                    end
                end
            end
        endfunction

        function void drive_breathing(logic on);
            if (st.red_mode == dlbb_pkg::MODE_BREATHE) st.pins[1] = on;
            if (st.green_mode == dlbb_pkg::MODE_BREATHE) st.pins[0] = on;
        endfunction

        // fast tick: one step of the breathing pwm
        function void pwm_tick();
            if (!st.pwm_en) return;
            st.pwm_phase = st.pwm_phase + 8'd1;
            if (st.pwm_phase > cfg.pwm_top) begin
                st.pwm_phase  = 8'd0;
                st.hold_count = st.hold_count + 8'd1;
                if (st.hold_count > cfg.ramp_hold) begin
                    st.hold_count = 8'd0;
                    if (st.ramp_up) begin
                        st.duty_width = st.duty_width + 8'd1;
                        if (st.duty_width > cfg.pwm_top) st.ramp_up = 1'b0;
                    end else begin
                        st.duty_width = st.duty_width - 8'd1;
                        if (st.duty_width < 8'd2) st.ramp_up = 1'b1;
                    end
                end
            end
            if (st.pwm_phase == 8'd0) drive_breathing(1'b0);
            else if (st.pwm_phase == st.duty_width) drive_breathing(1'b1);
        endfunction

        function void note_item(logic [1:0] op, logic led, logic [2:0] mode);
            case (op)
                dlbb_pkg::OP_SET_MODE:  apply_mode(led, mode);
                dlbb_pkg::OP_SLOW_TICK: blink_tick();
                dlbb_pkg::OP_FAST_TICK: pwm_tick();
                default: ;
            endcase
            outcome_q.push_back({st.red_mode, st.green_mode, st.pins});
        endfunction

        function void compare_field(string field_name, logic [2:0] want, logic [2:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field_name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (outcome_q.size() == 0) begin
                $display("%0t ns: unexpected result item, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = outcome_q.pop_front();
            compare_field("green_pin", {2'b0, want[0]}, {2'b0, got[0]});
            compare_field("red_pin", {2'b0, want[1]}, {2'b0, got[1]});
            compare_field("green_state", want[4:2], got[4:2]);
            compare_field("red_state", want[7:5], got[7:5]);
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [2:0] new_mode, [7:3] zero
    logic [2:0]  s_axis_tuser = '0;    // [1:0] opcode, [2] led_select
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] green_pin, [1] red_pin, [4:2] green_state,
                                       // [7:5] red_state
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    led_scoreboard sb;
    int          burst_left = 0;
    logic [9:0]  rx_cycle = '0;

    dual_led_blink_breathe_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // result side: stall pattern picked by the upper two bits of rx_cycle, then check the item
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 10'd1;
        case (rx_cycle[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 99) < 60);
            2'd2: m_axis_tready <= (rx_cycle[2:0] != 3'd0) && (rx_cycle[2:0] != 3'd3);
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // one input item; the sender runs in bursts with gaps between them
    task automatic send_item(input logic [1:0] op, input logic led, input logic [2:0] mode);
        if (burst_left == 0) begin
            if (s_axis_tvalid) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, mode};
        s_axis_tuser  <= {led, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, led, mode);
        burst_left--;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= {24'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic setup_regs(input logic [7:0] divide, input logic [7:0] limit,
                              input logic [7:0] top, input logic [7:0] hold);
        drain();
        write_reg(dlbb_pkg::REG_BLINK_DIVIDE, divide);
        write_reg(dlbb_pkg::REG_TEMP_BLINK_LIMIT, limit);
        write_reg(dlbb_pkg::REG_PWM_TOP, top);
        write_reg(dlbb_pkg::REG_RAMP_HOLD, hold);
        psel   <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // random mix: ticks dominate, set-mode commands steer the leds
    task automatic send_random(input int count);
        int         pick;
        logic [1:0] op;
        logic       led;
        logic [2:0] mode;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            led  = 1'($urandom_range(0, 1));
            mode = 3'($urandom_range(0, 7));
            if (pick < 25) begin
                op = dlbb_pkg::OP_SET_MODE;
                mode = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                      : $urandom_range(0, 4));
            end else if (pick < 60) begin
                op = dlbb_pkg::OP_SLOW_TICK;
            end else if (pick < 96) begin
                op = dlbb_pkg::OP_FAST_TICK;
            end else begin
                op = OP_UNUSED;
            end
            send_item(op, led, mode);
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items under the reset register values
        send_item(OP_UNUSED, 1'b1, 3'd7);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, dlbb_pkg::MODE_ON);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b1, dlbb_pkg::MODE_ON);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, 3'd5);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b1, 3'd7);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b1, dlbb_pkg::MODE_OFF);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, dlbb_pkg::MODE_BLINK);
        repeat (3) send_item(dlbb_pkg::OP_SLOW_TICK, 1'b0, 3'd0);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, dlbb_pkg::MODE_TEMP);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b1, dlbb_pkg::MODE_TEMP);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, dlbb_pkg::MODE_TEMP);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b1, dlbb_pkg::MODE_BREATHE);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, dlbb_pkg::MODE_BREATHE);
        repeat (3) send_item(dlbb_pkg::OP_FAST_TICK, 1'b1, 3'd7);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b1, dlbb_pkg::MODE_OFF);
        send_item(dlbb_pkg::OP_SET_MODE, 1'b0, dlbb_pkg::MODE_OFF);
        send_item(dlbb_pkg::OP_FAST_TICK, 1'b0, 3'd0);
        send_item(dlbb_pkg::OP_SLOW_TICK, 1'b1, 3'd7);
        send_random(110);

        // short periods: temp blink restores and the ramp turns quickly
        setup_regs(8'd1, 8'd1, 8'd3, 8'd1);
        send_random(110);

        // longest periods
        setup_regs(8'd255, 8'd255, 8'd254, 8'd255);
        send_random(110);

        setup_regs(8'd2, 8'd3, 8'd5, 8'd2);
        send_random(110);

        setup_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(3, 8)), 8'($urandom_range(1, 3)));
        send_random(110);

        drain();
        if (sb.errors == 0)
            $display("PASS dual_led_blink_breathe_controller");
        else
            $display("FAIL dual_led_blink_breathe_controller");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL dual_led_blink_breathe_controller");
        $finish;
    end

endmodule
